// ===== src/dfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU package
// Shared widths, command codes, the queued item type and the back-end states.
// ----------------------------------------------------------------------------
package dfpa_pkg;

	localparam int PORT_BITS      = 64;
	localparam int CMD_BITS       = 3;
	localparam int DIGIT_BITS     = 5;
	localparam int RES_DIGIT_BITS = 6;
	localparam int HALF_BITS      = 32;
	localparam int PROD_BITS      = 2 * PORT_BITS;
	localparam int DEC_BASE       = 10;
	localparam int DEC_HALF       = 5;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	localparam logic [CMD_BITS-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_SUB     = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_MUL     = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_LT      = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_EQ      = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_NEG     = 3'd5;
	localparam logic [CMD_BITS-1:0] CMD_RESCALE = 3'd6;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_LT,
		OP_EQ,
		OP_NEG,
		OP_RESCALE,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [PORT_BITS-1:0]  a;
		logic [DIGIT_BITS-1:0] ad;
		logic [PORT_BITS-1:0]  b;
		logic [DIGIT_BITS-1:0] bd;
		logic [DIGIT_BITS-1:0] td;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ALU,
		ST_MUL,
		ST_MFIN,
		ST_DIV,
		ST_DFIN,
		ST_EMIT
	} state_t;

endpackage

// ===== src/dfpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU front end
// Accepts items, decodes the command, wraps mantissas and clamps digit counts.
// ----------------------------------------------------------------------------
module dfpa_front #(
	parameter int MANTISSA_BITS       = 64,
	parameter int MAX_FRACTION_DIGITS = 18
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dfpa_pkg::CMD_BITS-1:0]      cmd,
	input  logic [dfpa_pkg::PORT_BITS-1:0]     a_mantissa,
	input  logic [dfpa_pkg::DIGIT_BITS-1:0]    a_digits,
	input  logic [dfpa_pkg::PORT_BITS-1:0]     b_mantissa,
	input  logic [dfpa_pkg::DIGIT_BITS-1:0]    b_digits,
	input  logic [dfpa_pkg::DIGIT_BITS-1:0]    target_digits,
	output logic                               push_valid,
	input  logic                               push_ready,
	output dfpa_pkg::item_t                    push_item
);
	import dfpa_pkg::*;

	localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = DIGIT_BITS'(MAX_FRACTION_DIGITS);

	logic  vld_s1;
	item_t item_s1;
	item_t item_d;
	logic  in_acc;

	function automatic logic [DIGIT_BITS-1:0] clamp(input logic [DIGIT_BITS-1:0] d);
		return (d > DIGIT_MAX) ? DIGIT_MAX : d;
	endfunction

	function automatic logic [PORT_BITS-1:0] wrap(input logic [PORT_BITS-1:0] m);
		logic signed [MANTISSA_BITS-1:0] w;
		w = m[MANTISSA_BITS-1:0];
		return PORT_BITS'(w);
	endfunction

	always_comb begin
		case (cmd)
			CMD_ADD:     item_d.op = OP_ADD;
			CMD_SUB:     item_d.op = OP_SUB;
			CMD_MUL:     item_d.op = OP_MUL;
			CMD_LT:      item_d.op = OP_LT;
			CMD_EQ:      item_d.op = OP_EQ;
			CMD_NEG:     item_d.op = OP_NEG;
			CMD_RESCALE: item_d.op = OP_RESCALE;
			default:     item_d.op = OP_NONE;
		endcase
		item_d.a  = wrap(a_mantissa);
		item_d.ad = clamp(a_digits);
		item_d.b  = wrap(b_mantissa);
		item_d.bd = clamp(b_digits);
		item_d.td = clamp(target_digits);
	end

	assign in_ready   = !vld_s1 || push_ready;
	assign in_acc     = in_valid && in_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== src/dfpa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module dfpa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  dfpa_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output dfpa_pkg::item_t pop_item
);
	import dfpa_pkg::*;

	localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

	item_t               entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = count_q != QUEUE_FULL;
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW + 1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== src/dfpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU back end
// Sequencer that scales by ten, divides by ten with rounding, multiplies in
// 32x32 partial products, and holds the result in an output register.
// ----------------------------------------------------------------------------
module dfpa_back #(
	parameter int MANTISSA_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  dfpa_pkg::item_t                     pop_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dfpa_pkg::PORT_BITS-1:0]      res_mantissa,
	output logic [dfpa_pkg::RES_DIGIT_BITS-1:0] res_digits,
	output logic                                compare_true,
	output logic                                overflow
);
	import dfpa_pkg::*;

	localparam int W = MANTISSA_BITS;
	localparam logic [PORT_BITS-1:0] MAX_POS64 =
		(PORT_BITS'(1) << (W - 1)) - PORT_BITS'(1);
	localparam logic [PORT_BITS-1:0] DIV_LIMIT64 = MAX_POS64 / PORT_BITS'(DEC_BASE);
	localparam logic signed [W-1:0] DIV_HI = DIV_LIMIT64[W-1:0];
	localparam logic signed [W-1:0] DIV_LO = -DIV_HI;
	localparam logic [W-1:0] MIN_WORD = {1'b1, {(W - 1){1'b0}}};
	localparam logic [PROD_BITS-1:0] LIMIT_POS = PROD_BITS'(MAX_POS64);
	localparam logic [PROD_BITS-1:0] LIMIT_NEG = LIMIT_POS + PROD_BITS'(1);
	localparam logic [2:0] DIV_LAST_STEP = 3'd5;
	localparam logic [2:0] MUL_LAST_STEP = 3'd4;
	localparam logic [4:0] REM_BASE = 5'(DEC_BASE);
	localparam logic [4:0] REM_HALF = 5'(DEC_HALF);

	state_t                    state_q;
	state_t                    state_d;
	op_t                       op_q;
	logic [W-1:0]              a_q;
	logic [W-1:0]              b_q;
	logic [DIGIT_BITS-1:0]     ad_q;
	logic [DIGIT_BITS-1:0]     bd_q;
	logic [DIGIT_BITS-1:0]     td_q;
	logic                      ovf_q;
	logic                      cmp_q;
	logic [W-1:0]              rm_q;
	logic [RES_DIGIT_BITS-1:0] rd_q;
	logic [W-1:0]              m_q;
	logic [W-1:0]              t_q;
	logic                      neg_q;
	logic [2:0]                step_q;
	logic [PORT_BITS-1:0]      ma_q;
	logic [PORT_BITS-1:0]      mb_q;
	logic [PORT_BITS-1:0]      pp_q;
	logic [1:0]                pp_sh_q;
	logic [PROD_BITS-1:0]      acc_q;
	logic                      out_valid_q;
	logic [PORT_BITS-1:0]      res_mantissa_q;
	logic [RES_DIGIT_BITS-1:0] res_digits_q;
	logic                      compare_true_q;
	logic                      overflow_q;

	logic                      is_rescale;
	logic                      up_a;
	logic                      up_b;
	logic                      lower;
	logic [W-1:0]              x;
	logic [W-1:0]              x10;
	logic                      x_ovf;
	logic [W-1:0]              sum;
	logic [W-1:0]              diff;
	logic                      add_ovf;
	logic                      sub_ovf;
	logic [W-1:0]              t_add;
	logic [W-1:0]              q;
	logic [4:0]                r5;
	logic                      r_big;
	logic [4:0]                rr;
	logic                      round_up;
	logic [W-1:0]              q_next;
	logic [HALF_BITS-1:0]      mul_x;
	logic [HALF_BITS-1:0]      mul_y;
	logic [1:0]                mul_sh;
	logic [PROD_BITS-1:0]      pp_shifted;
	logic [W-1:0]              prod_low;
	logic                      out_load;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (W'(0) - v) : v;
	endfunction

	// Times-ten unit shared by alignment and raising
	always_comb begin
		is_rescale = op_q == OP_RESCALE;
		up_a       = is_rescale ? (ad_q < td_q) : (ad_q < bd_q);
		up_b       = !is_rescale && (bd_q < ad_q);
		lower      = is_rescale && (ad_q > td_q);
		x          = up_a ? a_q : b_q;
		x10        = (x << 3) + (x << 1);
		x_ovf      = ($signed(x) > DIV_HI) || ($signed(x) < DIV_LO);
		sum        = a_q + b_q;
		diff       = a_q - b_q;
		add_ovf    = (a_q[W-1] == b_q[W-1]) && (sum[W-1] != a_q[W-1]);
		sub_ovf    = (a_q[W-1] != b_q[W-1]) && (diff[W-1] != a_q[W-1]);
	end

	// Divide-by-ten step on the magnitude
	always_comb begin
		case (step_q)
			3'd1:    t_add = t_q >> 4;
			3'd2:    t_add = t_q >> 8;
			3'd3:    t_add = t_q >> 16;
			default: t_add = t_q >> 32;
		endcase
		q        = t_q >> 3;
		r5       = m_q[4:0] - ({q[1:0], 3'b000} + {q[3:0], 1'b0});
		r_big    = r5 >= REM_BASE;
		rr       = r_big ? (r5 - REM_BASE) : r5;
		round_up = !neg_q && (rr >= REM_HALF);
		q_next   = q + W'(r_big) + W'(round_up);
	end

	// Partial product selection
	always_comb begin
		mul_x  = step_q[1] ? ma_q[PORT_BITS-1:HALF_BITS] : ma_q[HALF_BITS-1:0];
		mul_y  = step_q[0] ? mb_q[PORT_BITS-1:HALF_BITS] : mb_q[HALF_BITS-1:0];
		mul_sh = {step_q[1] & step_q[0], step_q[1] ^ step_q[0]};
		case (pp_sh_q)
			2'd0:    pp_shifted = PROD_BITS'(pp_q);
			2'd1:    pp_shifted = PROD_BITS'(pp_q) << HALF_BITS;
			default: pp_shifted = PROD_BITS'(pp_q) << PORT_BITS;
		endcase
		prod_low = acc_q[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					case (pop_item.op)
						OP_MUL:  state_d = ST_MUL;
						OP_NEG:  state_d = ST_ALU;
						OP_NONE: state_d = ST_ALU;
						default: state_d = ST_SCALE;
					endcase
				end
			end
			ST_SCALE: begin
				if (is_rescale) begin
					if (lower) begin
						state_d = ST_DIV;
					end else if (!up_a) begin
						state_d = ST_EMIT;
					end
				end else if (!up_a && !up_b) begin
					state_d = ST_ALU;
				end
			end
			ST_ALU:  state_d = ST_EMIT;
			ST_MUL: begin
				if (step_q == MUL_LAST_STEP) begin
					state_d = ST_MFIN;
				end
			end
			ST_MFIN: state_d = ST_EMIT;
			ST_DIV: begin
				if (step_q == DIV_LAST_STEP && (ad_q - DIGIT_BITS'(1)) == td_q) begin
					state_d = ST_DFIN;
				end
			end
			ST_DFIN: state_d = ST_EMIT;
			ST_EMIT: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					op_q   <= pop_item.op;
					a_q    <= pop_item.a[W-1:0];
					b_q    <= pop_item.b[W-1:0];
					ad_q   <= pop_item.ad;
					bd_q   <= pop_item.bd;
					td_q   <= pop_item.td;
					ovf_q  <= 1'b0;
					cmp_q  <= 1'b0;
					rm_q   <= '0;
					rd_q   <= '0;
					step_q <= '0;
					acc_q  <= '0;
					neg_q  <= pop_item.a[W-1] ^ pop_item.b[W-1];
					ma_q   <= PORT_BITS'(mag(pop_item.a[W-1:0]));
					mb_q   <= PORT_BITS'(mag(pop_item.b[W-1:0]));
				end
			end
			ST_SCALE: begin
				if (up_a) begin
					a_q   <= x10;
					ad_q  <= ad_q + DIGIT_BITS'(1);
					ovf_q <= ovf_q | x_ovf;
				end else if (up_b) begin
					b_q   <= x10;
					bd_q  <= bd_q + DIGIT_BITS'(1);
					ovf_q <= ovf_q | x_ovf;
				end else if (lower) begin
					m_q    <= mag(a_q);
					neg_q  <= a_q[W-1];
					step_q <= '0;
				end else if (is_rescale) begin
					rm_q <= a_q;
					rd_q <= RES_DIGIT_BITS'(ad_q);
				end
			end
			ST_ALU: begin
				case (op_q)
					OP_ADD: begin
						rm_q  <= sum;
						rd_q  <= RES_DIGIT_BITS'(ad_q);
						ovf_q <= ovf_q | add_ovf;
					end
					OP_SUB: begin
						rm_q  <= diff;
						rd_q  <= RES_DIGIT_BITS'(ad_q);
						ovf_q <= ovf_q | sub_ovf;
					end
					OP_LT:   cmp_q <= $signed(a_q) < $signed(b_q);
					OP_EQ:   cmp_q <= a_q == b_q;
					OP_NEG: begin
						rm_q  <= W'(0) - a_q;
						rd_q  <= RES_DIGIT_BITS'(ad_q);
						ovf_q <= a_q == MIN_WORD;
					end
					default: cmp_q <= 1'b0;
				endcase
			end
			ST_MUL: begin
				if (step_q != MUL_LAST_STEP) begin
					pp_q    <= PORT_BITS'(mul_x) * PORT_BITS'(mul_y);
					pp_sh_q <= mul_sh;
				end
				if (step_q != '0) begin
					acc_q <= acc_q + pp_shifted;
				end
				step_q <= step_q + 3'd1;
			end
			ST_MFIN: begin
				ovf_q <= acc_q > (neg_q ? LIMIT_NEG : LIMIT_POS);
				rm_q  <= neg_q ? (W'(0) - prod_low) : prod_low;
				rd_q  <= RES_DIGIT_BITS'(ad_q) + RES_DIGIT_BITS'(bd_q);
			end
			ST_DIV: begin
				case (step_q)
					3'd0: begin
						t_q    <= (m_q >> 1) + (m_q >> 2);
						step_q <= step_q + 3'd1;
					end
					DIV_LAST_STEP: begin
						m_q    <= q_next;
						ad_q   <= ad_q - DIGIT_BITS'(1);
						step_q <= '0;
					end
					default: begin
						t_q    <= t_q + t_add;
						step_q <= step_q + 3'd1;
					end
				endcase
			end
			ST_DFIN: begin
				rm_q <= neg_q ? (W'(0) - m_q) : m_q;
				rd_q <= RES_DIGIT_BITS'(ad_q);
			end
			default: begin
				rd_q <= rd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_mantissa_q <= PORT_BITS'($signed(rm_q));
			res_digits_q   <= rd_q;
			compare_true_q <= cmp_q;
			overflow_q     <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign res_mantissa = res_mantissa_q;
	assign res_digits   = res_digits_q;
	assign compare_true = compare_true_q;
	assign overflow     = overflow_q;

endmodule

// ===== src/decimal_fixed_point_alu_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU
// Add, subtract, multiply, compare, negate and rescale of decimal-scaled
// numbers (mantissa and fraction digit count).
//
// Input channel in_valid/in_ready carries cmd and both operands; output
// channel out_valid/out_ready returns one result item per input item.
// The front end decodes and registers an item and passes it through a
// two-entry queue, so it keeps taking items while the back end works or
// the output waits, until the queue and the front register are full.
// The back end runs one item at a time in steps of the scaling sequencer:
//   add, subtract, compare: a times-ten step per alignment digit, then ALU
//   negate: the ALU step; multiply: four 32x32 partial products, one per cycle
//   rescale: a times-ten step per added digit, or a rounding divide-by-ten
//   step per dropped digit (up to eighteen dropped digits)
// Each item passes the front register and the queue before the back end.
// Reset clears the valid state of every stage; no item is lost or repeated
// while the receiver holds out_ready low, the result register simply holds.
// ----------------------------------------------------------------------------
module decimal_fixed_point_alu_top #(
	parameter int MANTISSA_BITS       = 64,
	parameter int MAX_FRACTION_DIGITS = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dfpa_pkg::CMD_BITS-1:0]       cmd,
	input  logic [dfpa_pkg::PORT_BITS-1:0]      a_mantissa,
	input  logic [dfpa_pkg::DIGIT_BITS-1:0]     a_digits,
	input  logic [dfpa_pkg::PORT_BITS-1:0]      b_mantissa,
	input  logic [dfpa_pkg::DIGIT_BITS-1:0]     b_digits,
	input  logic [dfpa_pkg::DIGIT_BITS-1:0]     target_digits,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dfpa_pkg::PORT_BITS-1:0]      res_mantissa,
	output logic [dfpa_pkg::RES_DIGIT_BITS-1:0] res_digits,
	output logic                                compare_true,
	output logic                                overflow
);
	import dfpa_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	dfpa_front #(
		.MANTISSA_BITS       (MANTISSA_BITS),
		.MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.a_mantissa    (a_mantissa),
		.a_digits      (a_digits),
		.b_mantissa    (b_mantissa),
		.b_digits      (b_digits),
		.target_digits (target_digits),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	dfpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	dfpa_back #(
		.MANTISSA_BITS (MANTISSA_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.res_mantissa (res_mantissa),
		.res_digits   (res_digits),
		.compare_true (compare_true),
		.overflow     (overflow)
	);

endmodule

// ===== src/dfpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module dfpa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [dfpa_pkg::CMD_BITS-1:0]       cmd,
	input logic [dfpa_pkg::PORT_BITS-1:0]      a_mantissa,
	input logic [dfpa_pkg::DIGIT_BITS-1:0]     a_digits,
	input logic [dfpa_pkg::PORT_BITS-1:0]      b_mantissa,
	input logic [dfpa_pkg::DIGIT_BITS-1:0]     b_digits,
	input logic [dfpa_pkg::DIGIT_BITS-1:0]     target_digits,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [dfpa_pkg::PORT_BITS-1:0]      res_mantissa,
	input logic [dfpa_pkg::RES_DIGIT_BITS-1:0] res_digits,
	input logic                                compare_true,
	input logic                                overflow
);
	import dfpa_pkg::*;

	localparam logic [RES_DIGIT_BITS-1:0] RES_DIGIT_MAX = 6'd36;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(a_mantissa) &&
			$stable(a_digits) && $stable(b_mantissa) && $stable(b_digits) &&
			$stable(target_digits))
		else $error("input item changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_mantissa) &&
			$stable(res_digits) && $stable(compare_true) && $stable(overflow))
		else $error("result item changed while stalled");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> res_mantissa == '0 && res_digits == '0)
		else $error("compare item carries a nonzero mantissa or digit count");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res_digits <= RES_DIGIT_MAX)
		else $error("result digit count out of range");

endmodule

bind decimal_fixed_point_alu_top dfpa_checker u_dfpa_checker (.*);
